// ----- sv/bsbda_pkg.sv -----
// ----------------------------------------------------------------------------
// bsbda_pkg
// Shared types and constants of the bitmap-sparse bf16 dot accumulator.
// ----------------------------------------------------------------------------
package bsbda_pkg;

    localparam int unsigned LANES    = 16;
    localparam int unsigned SLOTS    = 32;
    localparam int unsigned ROW_W    = LANES * 32;
    localparam int unsigned GRP_W    = 5;
    localparam int unsigned PACKED_W = 64;

    typedef enum logic {
        CMD_MAC  = 1'b0,
        CMD_EMIT = 1'b1
    } cmd_t;

    // One classified request as it travels from front to back.
    typedef struct packed {
        cmd_t                   cmd;
        logic [GRP_W-1:0]       grp;
        logic                   oob;
        logic [15:0]            a0;
        logic [15:0]            a1;
        logic [SLOTS-1:0][15:0] w;
    } req_t;

endpackage

// ----- sv/bsbda_front.sv -----
// ----------------------------------------------------------------------------
// bsbda_front
// Input register, weight expansion by mask and bf16 flush, request classify.
// ----------------------------------------------------------------------------
module bsbda_front
    import bsbda_pkg::*;
#(
    parameter int GROUPS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [GRP_W-1:0]    s_group,
    input  logic [31:0]         s_mask,
    input  logic [31:0]         s_act_pair,
    input  logic [8*PACKED_W-1:0] s_packed,
    output logic                push,
    output req_t                push_req,
    input  logic                q_full
);

    logic                  in_v_reg;
    logic                  cmd_reg;
    logic [GRP_W-1:0]      grp_reg;
    logic [31:0]           mask_reg;
    logic [31:0]           act_reg;
    logic [8*PACKED_W-1:0] wpk_reg;
    logic                  oob;
    logic                  drop;
    logic                  consume;

    function automatic logic [15:0] daz16(input logic [15:0] h);
        if (h[14:7] == 8'd0) begin
            return {h[15], 15'd0};
        end
        return h;
    endfunction

    assign oob     = ({2'b00, grp_reg} >= 7'(GROUPS));
    // multiply-accumulate into a missing group does nothing
    assign drop    = in_v_reg && (cmd_reg == CMD_MAC) && oob;
    assign push    = in_v_reg && !drop && !q_full;
    assign consume = drop || push;
    assign s_ready = !in_v_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_ready) begin
            in_v_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg  <= s_cmd;
            grp_reg  <= s_group;
            mask_reg <= s_mask;
            act_reg  <= s_act_pair;
            wpk_reg  <= s_packed;
        end
    end

    // expandload: slot k takes packed weight number popcount(mask below k)
    always_comb begin
        logic [5:0]  idx;
        logic [31:0] below;
        push_req.cmd = cmd_t'(cmd_reg);
        push_req.grp = grp_reg;
        push_req.oob = oob;
        push_req.a0  = daz16(act_reg[15:0]);
        push_req.a1  = daz16(act_reg[31:16]);
        for (int k = 0; k < SLOTS; k++) begin
            below = (32'h1 << k) - 32'h1;
            idx   = 6'($countones(mask_reg & below));
            if (mask_reg[k]) begin
                push_req.w[k] = daz16(wpk_reg[idx[4:0]*16 +: 16]);
            end else begin
                push_req.w[k] = 16'd0;
            end
        end
    end

endmodule

// ----- sv/bsbda_queue.sv -----
// ----------------------------------------------------------------------------
// bsbda_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module bsbda_queue
    import bsbda_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  req_t push_req,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output req_t head_req
);

    req_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_req   = ent_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !(pop && head_valid)) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && pop && head_valid) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && head_valid) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ----- sv/bsbda_back.sv -----
// ----------------------------------------------------------------------------
// bsbda_back
// Accumulator memory, four-stage multiply-add pipeline and result register.
// ----------------------------------------------------------------------------
module bsbda_back
    import bsbda_pkg::*;
#(
    parameter int GROUPS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  req_t             head_req,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [GRP_W-1:0] m_group_out,
    output logic [ROW_W-1:0] m_row
);

    localparam int AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam logic [31:0] QBIT = 32'h0040_0000;
    localparam logic [31:0] DNAN = 32'hFFC0_0000;

    // bf16 x bf16 -> fp32; the 8x8 product is exact, only range matters
    function automatic logic [31:0] fmul(input logic [15:0] x, input logic [15:0] y);
        logic        s;
        logic [15:0] prod;
        logic [14:0] frac;
        logic signed [9:0] ex;
        s    = x[15] ^ y[15];
        prod = {1'b1, x[6:0]} * {1'b1, y[6:0]};
        frac = prod[15] ? prod[14:0] : {prod[13:0], 1'b0};
        ex   = $signed({2'b00, x[14:7]}) + $signed({2'b00, y[14:7]}) - 10'sd127
               + $signed({9'd0, prod[15]});
        if (x[14:7] == 8'hFF && x[6:0] != 7'd0) begin
            return {x, 16'd0} | QBIT;
        end
        if (y[14:7] == 8'hFF && y[6:0] != 7'd0) begin
            return {y, 16'd0} | QBIT;
        end
        if ((x[14:7] == 8'hFF && y[14:7] == 8'd0) || (x[14:7] == 8'd0 && y[14:7] == 8'hFF)) begin
            return DNAN;
        end
        if (x[14:7] == 8'hFF || y[14:7] == 8'hFF) begin
            return {s, 8'hFF, 23'd0};
        end
        if (x[14:7] == 8'd0 || y[14:7] == 8'd0 || ex <= 10'sd0) begin
            return {s, 31'd0};
        end
        if (ex >= 10'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, ex[7:0], frac, 8'd0};
    endfunction

    // fp32 add, nearest-even, denormals flushed; x is the accumulator
    function automatic logic [31:0] fadd(input logic [31:0] xi, input logic [31:0] y);
        logic [31:0] x;
        logic [31:0] b;
        logic [31:0] t;
        logic [7:0]  d;
        logic [26:0] ma;
        logic [26:0] mf;
        logic [26:0] sm;
        logic [27:0] sum;
        logic [26:0] m;
        logic [24:0] r;
        logic [4:0]  lz;
        logic        rnd;
        logic signed [9:0] e;
        x  = (xi[30:23] == 8'd0) ? {xi[31], 31'd0} : xi;
        b  = x;
        t  = y;
        if (y[30:0] > x[30:0]) begin
            b = y;
            t = x;
        end
        d  = b[30:23] - t[30:23];
        ma = {1'b1, b[22:0], 3'b000};
        mf = {1'b1, t[22:0], 3'b000};
        if (d >= 8'd27) begin
            sm = 27'd1;
        end else begin
            sm = mf >> d;
            sm[0] = sm[0] | (|(mf & ((27'd1 << d) - 27'd1)));
        end
        if (b[31] ^ t[31]) begin
            sum = {1'b0, ma} - {1'b0, sm};
        end else begin
            sum = {1'b0, ma} + {1'b0, sm};
        end
        lz = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (sum[i]) begin
                lz = 5'(26 - i);
            end
        end
        e = $signed({2'b00, b[30:23]});
        if (sum[27]) begin
            m = {sum[27:2], sum[1] | sum[0]};
            e = e + 10'sd1;
        end else begin
            m = sum[26:0] << lz;
            e = e - $signed({5'd0, lz});
        end
        rnd = m[2] & (m[1] | m[0] | m[3]);
        r   = {1'b0, m[26:3]} + {24'd0, rnd};
        if (r[24]) begin
            e = e + 10'sd1;
        end
        if (x[30:23] == 8'hFF && x[22:0] != 23'd0) begin
            return x | QBIT;
        end
        if (y[30:23] == 8'hFF && y[22:0] != 23'd0) begin
            return y | QBIT;
        end
        if (x[30:23] == 8'hFF && y[30:23] == 8'hFF) begin
            return (x[31] != y[31]) ? DNAN : x;
        end
        if (x[30:23] == 8'hFF) begin
            return x;
        end
        if (y[30:23] == 8'hFF) begin
            return y;
        end
        if (x[30:23] == 8'd0 && y[30:23] == 8'd0) begin
            return {x[31] & y[31], 31'd0};
        end
        if (x[30:23] == 8'd0) begin
            return y;
        end
        if (y[30:23] == 8'd0) begin
            return x;
        end
        if (sum == 28'd0) begin
            return 32'd0;
        end
        if (e >= 10'sd255) begin
            return {b[31], 8'hFF, 23'd0};
        end
        if (e <= 10'sd0) begin
            return {b[31], 31'd0};
        end
        return {b[31], e[7:0], r[24] ? 23'd0 : r[22:0]};
    endfunction

    logic [ROW_W-1:0]  acc_mem [GROUPS];
    logic [GROUPS-1:0] row_vld_reg;

    logic             s1_v_reg;
    req_t             s1_req_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_rowv_reg;

    logic                   s2_v_reg;
    logic [GRP_W-1:0]       s2_grp_reg;
    logic [LANES-1:0][31:0] s2_acc_reg;
    logic [LANES-1:0][31:0] s2_p1_reg;
    logic [LANES-1:0][31:0] s2_p0_reg;

    logic                   s3_v_reg;
    logic [GRP_W-1:0]       s3_grp_reg;
    logic [LANES-1:0][31:0] s3_acc_reg;
    logic [LANES-1:0][31:0] s3_p0_reg;

    logic                   s4_v_reg;
    logic [GRP_W-1:0]       s4_grp_reg;
    logic [LANES-1:0][31:0] s4_acc_reg;

    logic             m_valid_reg;
    logic             m_valid_next;
    logic [GRP_W-1:0] m_grp_reg;
    logic [ROW_W-1:0] m_row_reg;

    logic             s1_emit;
    logic             pipe_adv;
    logic             hazard;
    logic             out_load;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    s1_addr;
    logic [AW-1:0]    s4_addr;
    logic [5:0]       hd_grp6;
    logic [5:0]       s1_grp6;
    logic [5:0]       s4_grp6;
    logic [LANES-1:0][31:0] s1_acc;
    logic [LANES-1:0][31:0] p1;
    logic [LANES-1:0][31:0] p0;
    logic [LANES-1:0][31:0] acc1;
    logic [LANES-1:0][31:0] acc2;

    assign hd_grp6 = {1'b0, head_req.grp};
    assign s1_grp6 = {1'b0, s1_req_reg.grp};
    assign s4_grp6 = {1'b0, s4_grp_reg};
    assign rd_addr = hd_grp6[AW-1:0];
    assign s1_addr = s1_grp6[AW-1:0];
    assign s4_addr = s4_grp6[AW-1:0];

    assign s1_emit  = s1_v_reg && (s1_req_reg.cmd == CMD_EMIT);
    assign pipe_adv = !(s1_emit && m_valid_reg && !m_ready);
    // same group in flight: wait until its write-back has landed
    assign hazard   = (s1_v_reg && s1_req_reg.grp == head_req.grp)
                   || (s2_v_reg && s2_grp_reg == head_req.grp)
                   || (s3_v_reg && s3_grp_reg == head_req.grp)
                   || (s4_v_reg && s4_grp_reg == head_req.grp);
    assign pop      = pipe_adv && head_valid && !hazard;
    assign out_load = s1_emit && pipe_adv;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            s1_acc[j] = s1_rowv_reg ? s1_row_reg[j*32 +: 32] : 32'd0;
            p1[j]     = fmul(s1_req_reg.w[2*j+1], s1_req_reg.a1);
            p0[j]     = fmul(s1_req_reg.w[2*j], s1_req_reg.a0);
            acc1[j]   = fadd(s2_acc_reg[j], s2_p1_reg[j]);
            acc2[j]   = fadd(s3_acc_reg[j], s3_p0_reg[j]);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv && s4_v_reg) begin
            acc_mem[s4_addr] <= s4_acc_reg;
        end
        if (pipe_adv) begin
            s1_row_reg <= acc_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pipe_adv) begin
                s1_v_reg <= pop;
                s2_v_reg <= s1_v_reg && (s1_req_reg.cmd == CMD_MAC);
                s3_v_reg <= s2_v_reg;
                s4_v_reg <= s3_v_reg;
                if (s4_v_reg) begin
                    row_vld_reg[s4_addr] <= 1'b1;
                end
                if (s1_emit && !s1_req_reg.oob) begin
                    row_vld_reg[s1_addr] <= 1'b0;
                end
            end
        end
        if (pipe_adv) begin
            s1_req_reg  <= head_req;
            s1_rowv_reg <= row_vld_reg[rd_addr];
            s2_grp_reg  <= s1_req_reg.grp;
            s2_acc_reg  <= s1_acc;
            s2_p1_reg   <= p1;
            s2_p0_reg   <= p0;
            s3_grp_reg  <= s2_grp_reg;
            s3_acc_reg  <= acc1;
            s3_p0_reg   <= s2_p0_reg;
            s4_grp_reg  <= s3_grp_reg;
            s4_acc_reg  <= acc2;
        end
        if (out_load) begin
            m_grp_reg <= s1_req_reg.grp;
            m_row_reg <= s1_req_reg.oob ? '0 : s1_acc;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_group_out = m_grp_reg;
    assign m_row       = m_row_reg;

endmodule

// ----- sv/bitmap_sparse_bf16_dot_accumulate_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_sparse_bf16_dot_accumulate_unit
// Bitmap-sparse bf16 dot-product accumulator over GROUPS groups of 16 fp32 lanes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per accepted beat. A multiply-accumulate request
//   (s_cmd = 0) expands its packed bf16 weights by s_mask and adds, per lane j,
//   w[2j+1]*a1 and then w[2j]*a0 into lane j of group s_group. An emit request
//   (s_cmd = 1) returns the group's 16 lanes on the m_ channel and clears them.
//   Multiply-accumulate requests produce no result.
// Emit path: an emit passes the input register, the queue and the read stage
//   before m_valid rises, and waits longer on earlier work to the same group.
// Throughput: one request per cycle while successive requests hit different
//   groups and m_ready does not hold an emit. A request to a group still in
//   the four-stage multiply-add pipeline (read, multiply, add, add) waits for
//   its write-back, so requests to one group do not overlap in the pipeline.
// Reset: aresetn (synchronous, low) empties the pipeline and the queue and marks
//   every group as zero through per-group valid bits; no clearing pass is run.
// Stall: m_ready low holds the result register; new requests keep flowing in
//   until a further emit reaches the read stage of the back end, then the queue
//   fills and s_ready drops.
// ----------------------------------------------------------------------------
module bitmap_sparse_bf16_dot_accumulate_unit
    import bsbda_pkg::*;
#(
    parameter int GROUPS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [GRP_W-1:0]    s_group,
    input  logic [31:0]         s_mask,
    input  logic [31:0]         s_act_pair,
    input  logic [PACKED_W-1:0] s_packed_w0,
    input  logic [PACKED_W-1:0] s_packed_w1,
    input  logic [PACKED_W-1:0] s_packed_w2,
    input  logic [PACKED_W-1:0] s_packed_w3,
    input  logic [PACKED_W-1:0] s_packed_w4,
    input  logic [PACKED_W-1:0] s_packed_w5,
    input  logic [PACKED_W-1:0] s_packed_w6,
    input  logic [PACKED_W-1:0] s_packed_w7,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [GRP_W-1:0]    m_group_out,
    output logic [63:0]         m_lanes_0_1,
    output logic [63:0]         m_lanes_2_3,
    output logic [63:0]         m_lanes_4_5,
    output logic [63:0]         m_lanes_6_7,
    output logic [63:0]         m_lanes_8_9,
    output logic [63:0]         m_lanes_10_11,
    output logic [63:0]         m_lanes_12_13,
    output logic [63:0]         m_lanes_14_15
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             head_valid;
    req_t             push_req;
    req_t             head_req;
    logic [ROW_W-1:0] m_row;

    // front: register, expand weights, drop multiply-accumulate requests to missing groups
    bsbda_front #(.GROUPS(GROUPS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_group   (s_group),
        .s_mask    (s_mask),
        .s_act_pair(s_act_pair),
        .s_packed  ({s_packed_w7, s_packed_w6, s_packed_w5, s_packed_w4,
                     s_packed_w3, s_packed_w2, s_packed_w1, s_packed_w0}),
        .push      (push),
        .push_req  (push_req),
        .q_full    (q_full)
    );

    bsbda_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_req  (push_req),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_req  (head_req)
    );

    // back: accumulator read-modify-write and emit
    bsbda_back #(.GROUPS(GROUPS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_group_out(m_group_out),
        .m_row      (m_row)
    );

    assign m_lanes_0_1   = m_row[63:0];
    assign m_lanes_2_3   = m_row[127:64];
    assign m_lanes_4_5   = m_row[191:128];
    assign m_lanes_6_7   = m_row[255:192];
    assign m_lanes_8_9   = m_row[319:256];
    assign m_lanes_10_11 = m_row[383:320];
    assign m_lanes_12_13 = m_row[447:384];
    assign m_lanes_14_15 = m_row[511:448];

endmodule

// ----- sv/bsbda_checker.sv -----
// ----------------------------------------------------------------------------
// bsbda_checker
// Port-level checks for the dot accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module bsbda_checker
    import bsbda_pkg::*;
#(
    parameter int GROUPS = 32
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_cmd,
    input logic                m_valid,
    input logic                m_ready,
    input logic [GRP_W-1:0]    m_group_out,
    input logic [63:0]         m_lanes_0_1,
    input logic [63:0]         m_lanes_14_15
);

    // a waiting request stays offered with its command unchanged
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_cmd))
        else $error("request dropped or changed while waiting");

    // held result does not change in its group or lanes 0 and 1
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_group_out) && $stable(m_lanes_0_1))
        else $error("result changed while stalled");

    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a result needs at least the front, queue and read stages after reset
    a_min_lat: assert property (@(posedge aclk)
        $rose(m_valid) |-> $past(aresetn, 1) && $past(aresetn, 2) && $past(aresetn, 3))
        else $error("result sooner than pipeline latency");

    // emit of a missing group returns zero in lanes 0/1 and 14/15
    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ({2'b00, m_group_out} >= 7'(GROUPS)) |->
        m_lanes_0_1 == 64'd0 && m_lanes_14_15 == 64'd0)
        else $error("missing group gave nonzero lanes");

endmodule

bind bitmap_sparse_bf16_dot_accumulate_unit bsbda_checker #(.GROUPS(GROUPS)) u_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_cmd        (s_cmd),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_group_out  (m_group_out),
    .m_lanes_0_1  (m_lanes_0_1),
    .m_lanes_14_15(m_lanes_14_15)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap-sparse bf16 dot accumulator: a directed
// table then random traffic over all groups, with an fp32 predictor per lane.
// ----------------------------------------------------------------------------
module tb;
    import bsbda_pkg::*;

    localparam int NGRP      = 32;
    localparam int LIMIT     = 300000;
    localparam int N_RANDOM  = 2000;
    localparam int N_PHASE   = 5;
    localparam int DRAIN_CYC = 40;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

    // one input request
    typedef struct {
        cmd_t              cmd;
        logic [4:0]        grp;
        logic [31:0]       mask;
        logic [31:0]       act;
        logic [7:0][63:0]  pw;
    } req_item_t;

    // one emitted group
    typedef struct packed {
        logic [4:0]        grp;
        logic [15:0][31:0] lane;
    } emit_t;

    // directed row: typed_exp marks rows whose lanes 0/1 are known by hand
    typedef struct {
        req_item_t   item;
        bit          typed_exp;
        logic [63:0] lanes01;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd = 1'b0;
    logic [4:0] s_group = '0;
    logic [31:0] s_mask = '0;
    logic [31:0] s_act_pair = '0;
    logic [63:0] s_packed_w0 = '0, s_packed_w1 = '0, s_packed_w2 = '0, s_packed_w3 = '0;
    logic [63:0] s_packed_w4 = '0, s_packed_w5 = '0, s_packed_w6 = '0, s_packed_w7 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [4:0] m_group_out;
    logic [63:0] m_lanes_0_1, m_lanes_2_3, m_lanes_4_5, m_lanes_6_7;
    logic [63:0] m_lanes_8_9, m_lanes_10_11, m_lanes_12_13, m_lanes_14_15;

    bitmap_sparse_bf16_dot_accumulate_unit #(.GROUPS(NGRP)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_group(s_group),
        .s_mask(s_mask), .s_act_pair(s_act_pair),
        .s_packed_w0(s_packed_w0), .s_packed_w1(s_packed_w1),
        .s_packed_w2(s_packed_w2), .s_packed_w3(s_packed_w3),
        .s_packed_w4(s_packed_w4), .s_packed_w5(s_packed_w5),
        .s_packed_w6(s_packed_w6), .s_packed_w7(s_packed_w7),
        .m_valid(m_valid), .m_ready(m_ready), .m_group_out(m_group_out),
        .m_lanes_0_1(m_lanes_0_1), .m_lanes_2_3(m_lanes_2_3),
        .m_lanes_4_5(m_lanes_4_5), .m_lanes_6_7(m_lanes_6_7),
        .m_lanes_8_9(m_lanes_8_9), .m_lanes_10_11(m_lanes_10_11),
        .m_lanes_12_13(m_lanes_12_13), .m_lanes_14_15(m_lanes_14_15)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    int    err_cnt = 0;
    int    cycles = 0;
    int    send_idle_pct = 0;   // chance of an idle gap after each request
    int    recv_stall_pct = 0;  // chance of m_ready low per cycle
    logic  hold_go = 1'b0;
    logic  hold_on = 1'b0;
    emit_t emits_due[$];

    // predictor copy of the accumulator array
    logic [31:0] acc_mem [NGRP][16];

    // ------------------------------------------------------------------
    // fp32 arithmetic: round to nearest even, denormals in and out as zero
    // ------------------------------------------------------------------
    function automatic logic [31:0] ftz(logic [31:0] b);
        return (b[30:23] == 8'h00) ? {b[31], 31'h0} : b;
    endfunction

    function automatic bit is_nan(logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 0);
    endfunction

    // value = 1.m[62:0] * 2^e with m[63] set
    function automatic logic [31:0] round_pack(logic s, int e, logic [63:0] m);
        int          be;
        int          sh;
        logic [24:0] q;
        logic [31:0] r;
        be = e + 127;
        if (be >= 255) return {s, 8'hFF, 23'h0};
        if (be < 1) begin
            sh = 1 - be;
            if (sh > 63) m = 64'd1;
            else m = (m >> sh) | 64'(|(m & ((64'd1 << sh) - 1)));
            be = 1;
        end
        q = {1'b0, m[63:40]};
        if (m[39] && ((|m[38:0]) || q[0])) q = q + 1;
        // carry out of the mantissa rolls into the exponent, up to infinity
        r = (32'(be - 1) << 23) + 32'(q);
        return {s, r[30:0]};
    endfunction

    function automatic logic [31:0] f32_mul(logic [31:0] x, logic [31:0] y);
        logic        s;
        logic [63:0] t;
        int          e;
        s = x[31] ^ y[31];
        if (x[30:23] == 8'hFF || y[30:23] == 8'hFF) begin
            if (x[30:0] == 0 || y[30:0] == 0) return DEFAULT_NAN;
            return {s, 8'hFF, 23'h0};
        end
        if (x[30:0] == 0 || y[30:0] == 0) return {s, 31'h0};
        t = (64'({1'b1, x[22:0]}) * 64'({1'b1, y[22:0]})) << 16;
        e = int'(x[30:23]) + int'(y[30:23]) - 254;
        if (t[63]) e = e + 1;
        else t = t << 1;
        return round_pack(s, e, t);
    endfunction

    function automatic logic [31:0] f32_add(logic [31:0] x, logic [31:0] y);
        logic [31:0] big, lit;
        logic [63:0] ma, mb, sum;
        int          d, p;
        if (x[30:23] == 8'hFF) begin
            if (y[30:23] == 8'hFF && x[31] != y[31]) return DEFAULT_NAN;
            return x;
        end
        if (y[30:23] == 8'hFF) return y;
        if (x[30:0] == 0) return (y[30:0] == 0) ? {x[31] & y[31], 31'h0} : y;
        if (y[30:0] == 0) return x;
        if (x[30:0] >= y[30:0]) begin big = x; lit = y; end
        else begin big = y; lit = x; end
        d  = int'(big[30:23]) - int'(lit[30:23]);
        ma = 64'({1'b1, big[22:0]}) << 39;
        mb = 64'({1'b1, lit[22:0]}) << 39;
        if (d > 62) mb = 64'd1;
        else if (d > 0) mb = (mb >> d) | 64'(|(mb & ((64'd1 << d) - 1)));
        sum = (big[31] == lit[31]) ? ma + mb : ma - mb;
        if (sum == 0) return 32'h0;
        p = 63;
        while (!sum[p]) p--;
        return round_pack(big[31], int'(big[30:23]) - 127 + (p - 62), sum << (63 - p));
    endfunction

    // NaN operands propagate quietened, first operand wins
    function automatic logic [31:0] f32_op(logic [31:0] x, logic [31:0] y, bit mul);
        logic [31:0] r;
        if (is_nan(x)) return x | 32'h0040_0000;
        if (is_nan(y)) return y | 32'h0040_0000;
        r = mul ? f32_mul(x, y) : f32_add(x, y);
        return ftz(r);
    endfunction

    function automatic logic [31:0] bf16_to_f32(logic [15:0] h);
        return ftz({h, 16'h0});
    endfunction

    // apply one request to the accumulator copy; returns 1 with the emit
    function automatic bit accumulate_or_emit(req_item_t it, output emit_t res);
        logic [31:0] w [32];
        logic [31:0] a0, a1, acc, prod;
        int          nxt;
        res = '0;
        if (it.cmd == CMD_EMIT) begin
            res.grp = it.grp;
            for (int j = 0; j < 16; j++) begin
                res.lane[j] = acc_mem[it.grp][j];
                acc_mem[it.grp][j] = 32'h0;
            end
            return 1'b1;
        end
        a0  = bf16_to_f32(it.act[15:0]);
        a1  = bf16_to_f32(it.act[31:16]);
        nxt = 0;
        for (int k = 0; k < 32; k++) begin
            if (it.mask[k]) begin
                w[k] = bf16_to_f32(it.pw[nxt / 4][16 * (nxt % 4) +: 16]);
                nxt++;
            end else begin
                w[k] = 32'h0;
            end
        end
        for (int j = 0; j < 16; j++) begin
            acc  = acc_mem[it.grp][j];
            prod = f32_op(w[2 * j + 1], a1, 1'b1);
            acc  = f32_op(ftz(acc), prod, 1'b0);
            prod = f32_op(w[2 * j], a0, 1'b1);
            acc  = f32_op(ftz(acc), prod, 1'b0);
            acc_mem[it.grp][j] = acc;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] pick_bf16();
        int k;
        k = $urandom_range(99);
        if (k < 70) return {1'($urandom), 8'($urandom_range(135, 118)), 7'($urandom)};
        if (k < 80) begin
            case ($urandom_range(7))
                0: return 16'h0000;
                1: return 16'h8000;
                2: return 16'h7F80;              // +inf
                3: return 16'hFF80;              // -inf
                4: return 16'h7F81;              // signaling NaN
                5: return 16'h0041;              // denormal
                6: return 16'h7F7F;              // largest finite
                default: return 16'h0080;        // smallest normal
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic req_item_t random_req(bit emit);
        req_item_t it;
        int        m;
        it.cmd = emit ? CMD_EMIT : CMD_MAC;
        it.grp = 5'($urandom_range(NGRP - 1));
        m = $urandom_range(9);
        it.mask = (m == 0) ? 32'hFFFF_FFFF : (m == 1) ? 32'h0 : $urandom;
        it.act = {pick_bf16(), pick_bf16()};
        for (int i = 0; i < 8; i++)
            for (int q = 0; q < 4; q++)
                it.pw[i][16 * q +: 16] = (m == 9) ? 16'($urandom) : pick_bf16();
        return it;
    endfunction

    function automatic req_item_t mk(cmd_t c, logic [4:0] g, logic [31:0] msk,
                                     logic [31:0] act, logic [63:0] w0);
        req_item_t it;
        it.cmd = c; it.grp = g; it.mask = msk; it.act = act;
        it.pw = '0;
        it.pw[0] = w0;
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb: mismatch %s got %h want %h", what, got, want);
        err_cnt++;
    endtask

    // sends one request, predicts it once accepted, then maybe idles
    task automatic send_request(req_item_t it, bit typed, logic [63:0] lanes01);
        emit_t res;
        s_valid     <= 1'b1;
        s_cmd       <= it.cmd;
        s_group     <= it.grp;
        s_mask      <= it.mask;
        s_act_pair  <= it.act;
        s_packed_w0 <= it.pw[0]; s_packed_w1 <= it.pw[1];
        s_packed_w2 <= it.pw[2]; s_packed_w3 <= it.pw[3];
        s_packed_w4 <= it.pw[4]; s_packed_w5 <= it.pw[5];
        s_packed_w6 <= it.pw[6]; s_packed_w7 <= it.pw[7];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (accumulate_or_emit(it, res)) begin
            // hand-typed rows: the other 14 lanes are known to stay zero
            if (typed) begin
                res.lane = '0;
                res.lane[0] = lanes01[31:0];
                res.lane[1] = lanes01[63:32];
            end
            emits_due.push_back(res);
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, long hold-off, and the check
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        emit_t want;
        emit_t got;
        if (aresetn && m_valid && m_ready) begin
            got.grp = m_group_out;
            got.lane = {m_lanes_14_15, m_lanes_12_13, m_lanes_10_11, m_lanes_8_9,
                        m_lanes_6_7, m_lanes_4_5, m_lanes_2_3, m_lanes_0_1};
            if (emits_due.size() == 0) begin
                report_mismatch("unexpected emit, group", 64'(got.grp), 64'h0);
            end else begin
                want = emits_due.pop_front();
                if (got.grp !== want.grp)
                    report_mismatch("group_out", 64'(got.grp), 64'(want.grp));
                for (int p = 0; p < 8; p++)
                    if (got.lane[2 * p +: 2] !== want.lane[2 * p +: 2])
                        report_mismatch($sformatf("lanes_%0d_%0d", 2 * p, 2 * p + 1),
                                        got.lane[2 * p +: 2], want.lane[2 * p +: 2]);
            end
        end
        m_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off so the queue fills and s_ready drops
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_on <= 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    row_t dir_rows [$];

    initial begin
        req_item_t it;
        for (int g = 0; g < NGRP; g++)
            for (int j = 0; j < 16; j++) acc_mem[g][j] = 32'h0;

        // emit right after reset: all zero
        dir_rows.push_back('{mk(CMD_EMIT, 5'd3, 0, 0, 0), 1'b1, 64'h0});
        // slot 1 = 1.0, a1 = 2.0, a0 = 1.0: lane 0 = 2.0
        dir_rows.push_back('{mk(CMD_MAC, 5'd0, 32'h2, 32'h4000_3F80, 64'h3F80), 1'b0, 0});
        dir_rows.push_back('{mk(CMD_EMIT, 5'd0, 0, 0, 0), 1'b1, 64'h0000_0000_4000_0000});
        // inf * 0 gives the default NaN, which then sticks
        dir_rows.push_back('{mk(CMD_MAC, 5'd1, 32'h2, 32'h0, 64'h7F80), 1'b0, 0});
        dir_rows.push_back('{mk(CMD_EMIT, 5'd1, 0, 0, 0), 1'b1, {32'h0, DEFAULT_NAN}});
        // largest finite squared overflows to infinity
        dir_rows.push_back('{mk(CMD_MAC, 5'd31, 32'h1, 32'h7F7F_7F7F, 64'h7F7F), 1'b0, 0});
        dir_rows.push_back('{mk(CMD_EMIT, 5'd31, 0, 0, 0), 1'b1, 64'h0000_0000_7F80_0000});
        // signaling NaN weight is quietened
        dir_rows.push_back('{mk(CMD_MAC, 5'd2, 32'h1, 32'h3F80_3F80, 64'h7F81), 1'b0, 0});
        dir_rows.push_back('{mk(CMD_EMIT, 5'd2, 0, 0, 0), 1'b1, 64'h0000_0000_7FC1_0000});
        // denormal activation reads as zero
        dir_rows.push_back('{mk(CMD_MAC, 5'd4, 32'h3, 32'h0041_0041,
                                64'h3F80_3F80), 1'b0, 0});
        // full mask, unused packed weights ignored with sparse mask
        it = random_req(1'b0); it.grp = 5'd4; it.mask = 32'hFFFF_FFFF;
        dir_rows.push_back('{it, 1'b0, 0});
        it = random_req(1'b0); it.grp = 5'd4; it.mask = 32'h8000_0001;
        dir_rows.push_back('{it, 1'b0, 0});
        it = random_req(1'b0); it.grp = 5'd4; it.mask = 32'h0; it.pw = '1;
        dir_rows.push_back('{it, 1'b0, 0});
        dir_rows.push_back('{mk(CMD_EMIT, 5'd4, 0, 0, 0), 1'b0, 0});
        // infinities of both signs cancel to the default NaN
        dir_rows.push_back('{mk(CMD_MAC, 5'd5, 32'h3, 32'h3F80_3F80,
                                64'hFF80_7F80), 1'b0, 0});
        dir_rows.push_back('{mk(CMD_EMIT, 5'd5, 0, 0, 0), 1'b1, {32'h0, DEFAULT_NAN}});
        // tiny products flush to zero
        dir_rows.push_back('{mk(CMD_MAC, 5'd6, 32'h3, 32'h0080_0080,
                                64'h0080_0080), 1'b0, 0});
        dir_rows.push_back('{mk(CMD_EMIT, 5'd6, 0, 0, 0), 1'b0, 0});
        // emit twice: the second sees cleared lanes
        dir_rows.push_back('{mk(CMD_EMIT, 5'd6, 0, 0, 0), 1'b1, 64'h0});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r])
            send_request(dir_rows[r].item, dir_rows[r].typed_exp, dir_rows[r].lanes01);

        // random traffic in phases of idling
        for (int ph = 0; ph < N_PHASE; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                3: begin send_idle_pct = 18; recv_stall_pct = 18; end
                default: begin
                    send_idle_pct = 0; recv_stall_pct = 0;
                    hold_go <= 1'b1;
                end
            endcase
            for (int i = 0; i < N_RANDOM / N_PHASE; i++) begin
                it = random_req($urandom_range(7) == 0);
                // bursts onto a few groups to stress the read-modify-write hazard
                if ($urandom_range(3) == 0) it.grp = 5'($urandom_range(2));
                send_request(it, 1'b0, 0);
            end
        end
        // flush every group so all accumulated state gets checked
        for (int g = 0; g < NGRP; g++)
            send_request(mk(CMD_EMIT, 5'(g), 0, 0, 0), 1'b0, 0);
        s_valid <= 1'b0;

        while (emits_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/bsbda_pkg.sv
sv/bsbda_front.sv
sv/bsbda_queue.sv
sv/bsbda_back.sv
sv/bitmap_sparse_bf16_dot_accumulate_unit.sv
sv/bsbda_checker.sv
tb/tb.sv
